// ===== design/dcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Display command frame decoder package
// Shared types, constants and a lookup function for the frame decoder.
// ----------------------------------------------------------------------------
package dcfd_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Frame byte positions.
  localparam logic [CNT_W-1:0] IDX_ASSIST  = CNT_W'(3);
  localparam logic [CNT_W-1:0] IDX_B4      = CNT_W'(4);
  localparam logic [CNT_W-1:0] IDX_MOTOR   = CNT_W'(5);
  localparam logic [CNT_W-1:0] IDX_B6      = CNT_W'(6);
  localparam logic [CNT_W-1:0] IDX_CHECK   = CNT_W'(7);
  localparam logic [CNT_W-1:0] IDX_CURRENT = CNT_W'(9);
  localparam logic [CNT_W-1:0] LAST_IDX    = CNT_W'(FRAME_BYTES - 1);

  // Register indexes and reset values.
  localparam logic [1:0] REG_KEY  = 2'd0;
  localparam logic [1:0] REG_HDR1 = 2'd1;
  localparam logic [1:0] REG_HDR2 = 2'd2;
  localparam logic [7:0] KEY_RESET  = 8'd9;
  localparam logic [7:0] HDR1_RESET = 8'd50;
  localparam logic [7:0] HDR2_RESET = 8'd14;

  localparam logic [6:0] SPEED_BASE = 7'd10;

  // Speed limit = speed * (motor >> 1) * 1e8 / (3600 * wheel), reduced by 400.
  localparam int PROD_W = 14;
  localparam int NUM_W  = 32;
  localparam int DEN_W  = 22;
  localparam int QUO_W  = 16;
  localparam logic [17:0] NUM_SCALE = 18'd250000;
  localparam logic [QUO_W-1:0] ERPS_MAX = '1;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_LOAD  = 3'd1,
    BK_MUL   = 3'd2,
    BK_SCALE = 3'd3,
    BK_DIV   = 3'd4,
    BK_WRITE = 3'd5
  } back_state_t;

  typedef struct packed {
    logic [7:0] key;
    logic [7:0] hdr1;
    logic [7:0] hdr2;
  } cfg_t;

  // Classified frame handed from the framer to the decoder.
  typedef struct packed {
    logic [2:0] assist_level;
    logic [7:0] motor_constant;
    logic [4:0] wheel_code;
    logic [6:0] max_speed_kmh;
    logic       torque_mode;
    logic [3:0] current_code;
  } frame_fields_t;

  typedef struct packed {
    logic [2:0]  assist_level;
    logic [7:0]  motor_constant;
    logic [4:0]  wheel_code;
    logic [6:0]  max_speed_kmh;
    logic        torque_mode;
    logic [3:0]  current_code;
    logic [9:0]  current_factor_milli;
    logic [15:0] speed_limit_erps;
  } result_t;

  typedef struct packed {
    logic        hit;
    logic [17:0] len;
  } wheel_lookup_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } queue_status_t;

  localparam logic [3:0] CUR_LAST = 4'd10;
  localparam logic [9:0] CUR_MILLI [0:10] = '{
    10'd100, 10'd250, 10'd330, 10'd500, 10'd667, 10'd752,
    10'd800, 10'd833, 10'd870, 10'd910, 10'd1000
  };

  // Wheel circumference in units of 1e-5 m; codes not listed report no hit.
  function automatic wheel_lookup_t wheel_lookup(input logic [4:0] code);
    wheel_lookup_t r;
    r.hit = 1'b1;
    case (code)
      5'h12: r.len = 18'd46875;
      5'h0a: r.len = 18'd62847;
      5'h0e: r.len = 18'd78819;
      5'h02: r.len = 18'd94791;
      5'h06: r.len = 18'd110764;
      5'h00: r.len = 18'd126736;
      5'h04: r.len = 18'd142708;
      5'h08: r.len = 18'd157639;
      5'h0c: r.len = 18'd174305;
      5'h10: r.len = 18'd189583;
      5'h14: r.len = 18'd206250;
      5'h18: r.len = 18'd217361;
      5'h1c: r.len = 18'd219444;
      5'h1e: r.len = 18'd225000;
      default: begin
        r.hit = 1'b0;
        r.len = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/display_command_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Display command frame decoder
// Takes serial bytes, finds and checks 12-byte command frames and reports the
// decoded settings with a current factor and a speed limit.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the two-frame queue has room; the decoder
// takes one good frame at a time through its 16-step speed limit divider,
// so the last byte of a frame waits while the queue is full.
// Result path: a frame goes through the queue, then the decoder's load,
// multiply, scale, divide and write states; saturation skips the divide.
// Reset (rst, synchronous): framer hunts the first header, queue empty, wheel
// unknown, current factor zero, registers at their defaults.
module display_command_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] assist_level, [10:3] motor_constant, [15:11] wheel_code,
  // [22:16] max_speed_kmh, [23] torque_mode, [27:24] current_code,
  // [37:28] current_factor_milli, [53:38] speed_limit_erps, [55:54] zero
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  dcfd_pkg::cfg_t          cfg;
  dcfd_pkg::frame_fields_t push_data, pop_data;
  dcfd_pkg::queue_status_t q_status;
  dcfd_pkg::result_t       res;
  logic                    push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key  <= dcfd_pkg::KEY_RESET;
      cfg.hdr1 <= dcfd_pkg::HDR1_RESET;
      cfg.hdr2 <= dcfd_pkg::HDR2_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcfd_pkg::REG_KEY:  cfg.key  <= cfg_data;
        dcfd_pkg::REG_HDR1: cfg.hdr1 <= cfg_data;
        dcfd_pkg::REG_HDR2: cfg.hdr2 <= cfg_data;
        default: ;
      endcase
    end
  end

  dcfd_framer u_framer (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg           (cfg),
    .q_full        (q_status.full),
    .push          (push),
    .push_data     (push_data)
  );

  dcfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  dcfd_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {2'b00, res.speed_limit_erps, res.current_factor_milli,
                         res.current_code, res.torque_mode, res.max_speed_kmh,
                         res.wheel_code, res.motor_constant, res.assist_level};

endmodule

// ===== design/dcfd_framer.sv =====
// ----------------------------------------------------------------------------
// Frame hunter and checker
// Finds the two header bytes, gathers the frame body, checks the XOR sum and
// pushes the extracted fields of a good frame into the queue.
// ----------------------------------------------------------------------------
module dcfd_framer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  dcfd_pkg::cfg_t         cfg,
  input  logic                   q_full,
  output logic                   push,
  output dcfd_pkg::frame_fields_t push_data
);

  dcfd_pkg::phase_t             phase, phase_next;
  logic [dcfd_pkg::CNT_W-1:0]   count, count_next;
  logic [7:0]                   acc;
  logic [7:0]                   b3, b4, b5, b6, b7, b9;
  logic [7:0]                   e3, e4, e5, e6, e7, e9;
  logic [7:0]                   sum;
  logic                         accept;
  logic                         last;

  assign last   = (phase == dcfd_pkg::PH_BODY) && (count == dcfd_pkg::LAST_IDX);
  assign s_axis_tready = !(last && q_full);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Next state of the framer.
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (accept) begin
      case (phase)
        dcfd_pkg::PH_HUNT2: begin
          if (s_axis_tdata == cfg.hdr2) begin
            phase_next = dcfd_pkg::PH_BODY;
            count_next = dcfd_pkg::CNT_W'(2);
          end else begin
            phase_next = dcfd_pkg::PH_HUNT1;
            count_next = '0;
          end
        end
        dcfd_pkg::PH_BODY: begin
          if (last) begin
            phase_next = dcfd_pkg::PH_HUNT1;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
        default: begin
          if (s_axis_tdata == cfg.hdr1) begin
            phase_next = dcfd_pkg::PH_HUNT2;
            count_next = dcfd_pkg::CNT_W'(1);
          end else begin
            phase_next = dcfd_pkg::PH_HUNT1;
            count_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dcfd_pkg::PH_HUNT1;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // The running XOR skips the check byte; header bytes are part of it.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        dcfd_pkg::PH_HUNT2: acc <= acc ^ s_axis_tdata;
        dcfd_pkg::PH_BODY: begin
          if (count != dcfd_pkg::IDX_CHECK) acc <= acc ^ s_axis_tdata;
          if (count == dcfd_pkg::IDX_ASSIST)  b3 <= s_axis_tdata;
          if (count == dcfd_pkg::IDX_B4)      b4 <= s_axis_tdata;
          if (count == dcfd_pkg::IDX_MOTOR)   b5 <= s_axis_tdata;
          if (count == dcfd_pkg::IDX_B6)      b6 <= s_axis_tdata;
          if (count == dcfd_pkg::IDX_CHECK)   b7 <= s_axis_tdata;
          if (count == dcfd_pkg::IDX_CURRENT) b9 <= s_axis_tdata;
        end
        default: acc <= s_axis_tdata;
      endcase
    end
  end

  // The current byte bypasses its capture register when it is at a captured position.
  always_comb begin
    e3  = (count == dcfd_pkg::IDX_ASSIST)  ? s_axis_tdata : b3;
    e4  = (count == dcfd_pkg::IDX_B4)      ? s_axis_tdata : b4;
    e5  = (count == dcfd_pkg::IDX_MOTOR)   ? s_axis_tdata : b5;
    e6  = (count == dcfd_pkg::IDX_B6)      ? s_axis_tdata : b6;
    e7  = (count == dcfd_pkg::IDX_CHECK)   ? s_axis_tdata : b7;
    e9  = (count == dcfd_pkg::IDX_CURRENT) ? s_axis_tdata : b9;
    sum = (count == dcfd_pkg::IDX_CHECK)   ? acc : (acc ^ s_axis_tdata);
  end

  // Outputs toward the queue.
  always_comb begin
    push = accept && last && ((sum ^ cfg.key) == e7);
    push_data.assist_level   = e3[2:0];
    push_data.motor_constant = e5;
    push_data.wheel_code     = {e4[2:0], e6[7:6]};
    push_data.max_speed_kmh  = dcfd_pkg::SPEED_BASE + {1'b0, e6[5], e4[7:3]};
    push_data.torque_mode    = e6[3];
    push_data.current_code   = e9[3:0];
  end

endmodule

// ===== design/dcfd_queue.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Short first-in first-out buffer of checked frames between framer and decoder.
// ----------------------------------------------------------------------------
module dcfd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dcfd_pkg::frame_fields_t push_data,
  input  logic                    pop,
  output dcfd_pkg::frame_fields_t pop_data,
  output dcfd_pkg::queue_status_t status
);

  dcfd_pkg::frame_fields_t       mem [0:dcfd_pkg::QUEUE_DEPTH-1];
  logic [dcfd_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [dcfd_pkg::QPTR_W:0]     fill;

  assign status.full  = (fill == (dcfd_pkg::QPTR_W+1)'(dcfd_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("frame queue read while empty");

endmodule

// ===== design/dcfd_decoder.sv =====
// ----------------------------------------------------------------------------
// Frame decoder
// Applies the wheel and current tables, computes the speed limit with a
// radix-2 divider and holds the result in the output register.
// ----------------------------------------------------------------------------
module dcfd_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  dcfd_pkg::queue_status_t q_status,
  input  dcfd_pkg::frame_fields_t q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dcfd_pkg::result_t       out_data
);

  dcfd_pkg::back_state_t           state, state_next;
  dcfd_pkg::frame_fields_t         f;
  dcfd_pkg::wheel_lookup_t         wl;
  logic [17:0]                     wheel_length;
  logic [9:0]                      current_factor;
  logic [dcfd_pkg::PROD_W-1:0]     prod;
  logic [dcfd_pkg::NUM_W-1:0]      num;
  logic [dcfd_pkg::DEN_W-1:0]      den;
  logic [dcfd_pkg::DEN_W-1:0]      rem;
  logic [dcfd_pkg::QUO_W-1:0]      qsh;
  logic [3:0]                      step;
  logic                            no_wheel;
  logic                            saturate;
  logic [dcfd_pkg::DEN_W:0]        trial;
  logic                            trial_ge;
  logic                            out_free;
  logic                            load_out;

  assign wl       = dcfd_pkg::wheel_lookup(f.wheel_code);
  assign out_free = !out_valid || out_ready;
  assign saturate = no_wheel ||
                    ({{(dcfd_pkg::DEN_W-16){1'b0}}, num[dcfd_pkg::NUM_W-1:16]} >= den);
  assign trial    = {rem, qsh[dcfd_pkg::QUO_W-1]};
  assign trial_ge = trial >= {1'b0, den};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dcfd_pkg::BK_IDLE:  if (!q_status.empty) state_next = dcfd_pkg::BK_LOAD;
      dcfd_pkg::BK_LOAD:  state_next = dcfd_pkg::BK_MUL;
      dcfd_pkg::BK_MUL:   state_next = dcfd_pkg::BK_SCALE;
      dcfd_pkg::BK_SCALE: state_next = saturate ? dcfd_pkg::BK_WRITE : dcfd_pkg::BK_DIV;
      dcfd_pkg::BK_DIV:   if (step == 4'd15) state_next = dcfd_pkg::BK_WRITE;
      dcfd_pkg::BK_WRITE: if (out_free) state_next = dcfd_pkg::BK_IDLE;
      default:            state_next = dcfd_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      dcfd_pkg::BK_IDLE:  pop = !q_status.empty;
      dcfd_pkg::BK_WRITE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dcfd_pkg::BK_IDLE;
      wheel_length   <= '0;
      current_factor <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dcfd_pkg::BK_LOAD) begin
        if (wl.hit) wheel_length <= wl.len;
        if (f.current_code <= dcfd_pkg::CUR_LAST)
          current_factor <= dcfd_pkg::CUR_MILLI[f.current_code];
      end
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath: one multiply per stage, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state)
      dcfd_pkg::BK_IDLE: f <= q_data;
      dcfd_pkg::BK_LOAD:
        prod <= dcfd_pkg::PROD_W'(f.max_speed_kmh * {1'b0, f.motor_constant[7:1]});
      dcfd_pkg::BK_MUL: begin
        num      <= dcfd_pkg::NUM_W'(prod * dcfd_pkg::NUM_SCALE);
        den      <= {wheel_length, 3'b000} + dcfd_pkg::DEN_W'(wheel_length);
        no_wheel <= (wheel_length == '0);
      end
      dcfd_pkg::BK_SCALE: begin
        rem  <= dcfd_pkg::DEN_W'(num[dcfd_pkg::NUM_W-1:16]);
        qsh  <= saturate ? dcfd_pkg::ERPS_MAX : num[15:0];
        step <= '0;
      end
      dcfd_pkg::BK_DIV: begin
        rem  <= trial_ge ? dcfd_pkg::DEN_W'(trial - {1'b0, den}) : trial[dcfd_pkg::DEN_W-1:0];
        qsh  <= {qsh[dcfd_pkg::QUO_W-2:0], trial_ge};
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.assist_level         <= f.assist_level;
      out_data.motor_constant       <= f.motor_constant;
      out_data.wheel_code           <= f.wheel_code;
      out_data.max_speed_kmh        <= f.max_speed_kmh;
      out_data.torque_mode          <= f.torque_mode;
      out_data.current_code         <= f.current_code;
      out_data.current_factor_milli <= current_factor;
      out_data.speed_limit_erps     <= qsh;
    end
  end

  a_no_wheel_saturates: assert property (@(posedge clk) disable iff (rst)
    (state == dcfd_pkg::BK_SCALE && no_wheel) |=> (state == dcfd_pkg::BK_WRITE))
    else $error("missing wheel did not saturate the speed limit");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("finished frame not presented at the output");

endmodule
